// ===== sv/assert_macros.svh =====
// Assertion macros shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define SKF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define SKF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/skf_pkg.sv =====
// Shared types and constants of the scalar Kalman filter.
package skf_pkg;

    localparam int CFG_WIDTH   = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_COVARIANCE = 3'd3;

    localparam logic [CFG_WIDTH-1:0] RESET_PROCESS_NOISE      = 32'd0;
    localparam logic [CFG_WIDTH-1:0] RESET_MEASUREMENT_NOISE  = 32'd65536;
    localparam logic [CFG_WIDTH-1:0] RESET_INITIAL_ESTIMATE   = 32'd0;
    localparam logic [CFG_WIDTH-1:0] RESET_INITIAL_COVARIANCE = 32'd65536;
    localparam logic [CFG_WIDTH-1:0] RESET_COVARIANCE         = 32'd65536;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic load;      // input transfer: capture sample and starting state
        logic prep;      // form P+R, the difference and the divider seed
        logic div_step;  // one restoring division step
        logic gain_set;  // clamp the quotient and start the estimate product
        logic mul_step;  // one shift-add multiplier step
        logic cov_set;   // keep the estimate delta, start the covariance product
        logic commit;    // update state and load the output register
    } skf_cmd_t;

endpackage

// ===== sv/scalar_kalman_filter_unit.sv =====
// Top level of the scalar Kalman filter unit.
// One-dimensional Kalman filter on signed fixed-point samples (Q16.16 by default).
// Each transfer on the s_ channel produces exactly one result on the m_ channel.
// A new sample is taken only once the previous result has been committed. The gain
// P/(P+R) comes from a restoring divider that yields one quotient bit per cycle,
// and the two products share one shift-add multiplier that consumes one gain bit
// per cycle. The result sits in an output register, so the next sample is taken
// while it waits; the datapath stalls only when a second result is ready before
// the first has been transferred.
// Configuration writes are always taken and must only be issued while idle.
module scalar_kalman_filter_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [skf_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [DATA_WIDTH-1:0]         s_measurement,
    input  logic                                 s_restart,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [DATA_WIDTH-1:0]         m_new_estimate,
    output logic [DATA_WIDTH-1:0]                m_new_covariance,
    output logic [FRAC_BITS:0]                   m_gain_used,
    output logic                                 m_zero_denominator,
    output logic                                 m_saturated
);

    skf_pkg::skf_cmd_t cmd;

    assign cfg_ready = 1'b1;

    skf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    skf_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg_write          (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_measurement      (s_measurement),
        .s_restart          (s_restart),
        .m_new_estimate     (m_new_estimate),
        .m_new_covariance   (m_new_covariance),
        .m_gain_used        (m_gain_used),
        .m_zero_denominator (m_zero_denominator),
        .m_saturated        (m_saturated)
    );

endmodule

// ===== sv/skf_ctrl.sv =====
// Sequencing state machine of the scalar Kalman filter.
module skf_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output skf_pkg::skf_cmd_t cmd
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_PREP    = 8'b0000_0010,
        S_DIV     = 8'b0000_0100,
        S_GAIN    = 8'b0000_1000,
        S_MUL_EST = 8'b0001_0000,
        S_COV_SET = 8'b0010_0000,
        S_MUL_COV = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = CW'(FRAC_BITS - 1);
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN: begin
                cmd.gain_set = 1'b1;
                cnt_next     = CW'(FRAC_BITS);
                state_next   = S_MUL_EST;
            end
            S_MUL_EST: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_COV_SET;
                end
            end
            S_COV_SET: begin
                cmd.cov_set = 1'b1;
                cnt_next    = CW'(FRAC_BITS);
                state_next  = S_MUL_COV;
            end
            S_MUL_COV: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // Wait here until the output register can take the result.
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

`include "assert_macros.svh"

    `SKF_ASSERT(a_accept_to_prep, s_valid && s_ready |=> state_reg == S_PREP, "accept did not start")
    `SKF_ASSERT(a_commit_shows, cmd.commit |=> m_valid_reg, "committed result not presented")
    `SKF_ASSERT(a_finish_holds, state_reg == S_FINISH && !out_free |=> state_reg == S_FINISH, "result dropped while output busy")
    `SKF_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> state_reg == S_IDLE && !m_valid_reg, "reset did not clear controller")

endmodule

// ===== sv/skf_datapath.sv =====
// Datapath of the scalar Kalman filter: registers, divider and shift-add multiplier.
module skf_datapath #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  skf_pkg::skf_cmd_t                    cmd,
    input  logic                                 cfg_write,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [skf_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic signed [DATA_WIDTH-1:0]         s_measurement,
    input  logic                                 s_restart,
    output logic signed [DATA_WIDTH-1:0]         m_new_estimate,
    output logic [DATA_WIDTH-1:0]                m_new_covariance,
    output logic [FRAC_BITS:0]                   m_gain_used,
    output logic                                 m_zero_denominator,
    output logic                                 m_saturated
);

    localparam int DW = DATA_WIDTH;
    localparam int GW = FRAC_BITS + 1;       // gain, 1.0 included
    localparam int RW = DW + 2;              // divider remainder after the shift
    localparam int XW = DW + 2;              // multiplicand, signed
    localparam int PW = XW + GW;             // product accumulator
    localparam int EW = PW - FRAC_BITS;      // shifted product
    localparam logic [GW-1:0] ONE_G = GW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] SMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN  = {1'b1, {(DW-1){1'b0}}};

    logic [skf_pkg::CFG_WIDTH-1:0] q_cfg_reg, r_cfg_reg, e0_cfg_reg, p0_cfg_reg;
    logic [DW-1:0]  est_reg, cov_reg;
    logic [DW-1:0]  z_reg, p_reg, e_reg;
    logic [DW:0]    d_reg;
    logic [DW:0]    diff_reg;
    logic           zero_reg;
    logic [RW-1:0]  rem_reg;
    logic [GW-1:0]  quo_reg, g_reg, m_reg;
    logic [XW-1:0]  x_reg;
    logic [PW-1:0]  acc_reg;
    logic [EW-1:0]  delta_reg;

    logic [DW-1:0]  q_dw, r_dw;
    logic [DW:0]    d_next;
    logic [RW-1:0]  rem_sh;
    logic           rem_ge;
    logic [GW-1:0]  gain_c;
    logic [PW-1:0]  addend;
    logic [EW-1:0]  est_sum;
    logic           est_over, est_under;
    logic [DW:0]    cov_sum;
    logic [DW-1:0]  est_final, cov_final;

    assign q_dw = DW'(q_cfg_reg);
    assign r_dw = DW'(r_cfg_reg);

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cfg_reg  <= skf_pkg::RESET_PROCESS_NOISE;
            r_cfg_reg  <= skf_pkg::RESET_MEASUREMENT_NOISE;
            e0_cfg_reg <= skf_pkg::RESET_INITIAL_ESTIMATE;
            p0_cfg_reg <= skf_pkg::RESET_INITIAL_COVARIANCE;
        end else if (cfg_write) begin
            case (cfg_index)
                skf_pkg::REG_PROCESS_NOISE:      q_cfg_reg  <= cfg_data;
                skf_pkg::REG_MEASUREMENT_NOISE:  r_cfg_reg  <= cfg_data;
                skf_pkg::REG_INITIAL_ESTIMATE:   e0_cfg_reg <= cfg_data;
                skf_pkg::REG_INITIAL_COVARIANCE: p0_cfg_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign d_next = {1'b0, p_reg} + {1'b0, r_dw};

    assign rem_sh = {rem_reg[RW-2:0], 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, d_reg});

    always_comb begin
        if (zero_reg) begin
            gain_c = '0;
        end else if (quo_reg > ONE_G) begin
            gain_c = ONE_G;
        end else begin
            gain_c = quo_reg;
        end
    end

    // The multiplier walks the gain from its top bit: acc = 2*acc + bit*x.
    assign addend = m_reg[GW-1] ? {{GW{x_reg[XW-1]}}, x_reg} : '0;

    // Final sums; the estimate is range-checked on its top bits.
    assign est_sum   = delta_reg + {{(EW-DW){e_reg[DW-1]}}, e_reg};
    assign est_over  = !est_sum[EW-1] && (est_sum[EW-2:DW-1] != '0);
    assign est_under = est_sum[EW-1] && (est_sum[EW-2:DW-1] != '1);
    assign cov_sum   = {1'b0, acc_reg[FRAC_BITS+DW-1:FRAC_BITS]} + {1'b0, q_dw};

    always_comb begin
        if (est_over) begin
            est_final = SMAX;
        end else if (est_under) begin
            est_final = SMIN;
        end else begin
            est_final = est_sum[DW-1:0];
        end
        cov_final = cov_sum[DW] ? '1 : cov_sum[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg <= '0;
            cov_reg <= DW'(skf_pkg::RESET_COVARIANCE);
        end else if (cmd.commit) begin
            est_reg <= est_final;
            cov_reg <= cov_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            z_reg <= s_measurement;
            p_reg <= s_restart ? DW'(p0_cfg_reg) : cov_reg;
            e_reg <= s_restart ? DW'(e0_cfg_reg) : est_reg;
        end
        if (cmd.prep) begin
            d_reg    <= d_next;
            zero_reg <= (d_next == '0);
            diff_reg <= {z_reg[DW-1], z_reg} - {e_reg[DW-1], e_reg};
            // With R zero the integer quotient bit is one and nothing remains.
            rem_reg  <= (r_dw == '0) ? '0 : RW'(p_reg);
            quo_reg  <= GW'(r_dw == '0);
        end
        if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_sh - {1'b0, d_reg} : rem_sh;
            quo_reg <= {quo_reg[GW-2:0], rem_ge};
        end
        if (cmd.gain_set) begin
            g_reg   <= gain_c;
            m_reg   <= gain_c;
            x_reg   <= {diff_reg[DW], diff_reg};
            acc_reg <= '0;
        end
        if (cmd.mul_step) begin
            acc_reg <= {acc_reg[PW-2:0], 1'b0} + addend;
            m_reg   <= {m_reg[GW-2:0], 1'b0};
        end
        if (cmd.cov_set) begin
            delta_reg <= acc_reg[PW-1:FRAC_BITS];
            x_reg     <= {2'b00, p_reg};
            m_reg     <= ONE_G - g_reg;
            acc_reg   <= '0;
        end
        if (cmd.commit) begin
            m_new_estimate     <= est_final;
            m_new_covariance   <= cov_final;
            m_gain_used        <= g_reg;
            m_zero_denominator <= zero_reg;
            m_saturated        <= est_over || est_under || cov_sum[DW];
        end
    end

`include "assert_macros.svh"

    `SKF_ASSERT(a_gain_range, cmd.mul_step |-> g_reg <= ONE_G, "gain above one")
    `SKF_ASSERT(a_zero_gain, cmd.commit && zero_reg |=> m_gain_used == '0 && m_zero_denominator, "zero denominator with nonzero gain")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the scalar Kalman filter unit, with its own update predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int DW          = 32;
    localparam int FB          = 16;
    localparam int ITEM_CYCLES = 3 * FB + 7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 157;

    localparam longint EST_MAX = (longint'(1) << (DW - 1)) - 1;
    localparam longint EST_MIN = -EST_MAX - 1;
    localparam longint COV_MAX = (longint'(1) << DW) - 1;
    localparam longint GAIN_ONE = longint'(1) << FB;

    typedef struct {
        logic [DW-1:0] z;
        logic          restart;
    } sample_t;

    typedef struct {
        logic signed [DW-1:0] estimate;
        logic [DW-1:0]        covariance;
        logic [FB:0]          gain;
        logic                 zero_den;
        logic                 sat;
    } update_t;

    logic                            aclk;
    logic                            aresetn = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [skf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [skf_pkg::CFG_WIDTH-1:0]   cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic signed [DW-1:0]            s_measurement = '0;
    logic                            s_restart = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic signed [DW-1:0]            m_new_estimate;
    logic [DW-1:0]                   m_new_covariance;
    logic [FB:0]                     m_gain_used;
    logic                            m_zero_denominator;
    logic                            m_saturated;

    // Register copies and filter state as the predictor sees them.
    logic [DW-1:0]        q_noise  = skf_pkg::RESET_PROCESS_NOISE;
    logic [DW-1:0]        r_noise  = skf_pkg::RESET_MEASUREMENT_NOISE;
    logic signed [DW-1:0] init_est = skf_pkg::RESET_INITIAL_ESTIMATE;
    logic [DW-1:0]        init_cov = skf_pkg::RESET_INITIAL_COVARIANCE;
    logic signed [DW-1:0] est_q    = '0;
    logic [DW-1:0]        cov_q    = skf_pkg::RESET_COVARIANCE;

    sample_t pending_samples[$];
    update_t expected_updates[$];

    int unsigned items_queued    = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned src_gap         = 0;
    int unsigned snk_gap         = 0;
    int unsigned src_idle_pct    = 0;
    int unsigned snk_idle_pct    = 0;

    scalar_kalman_filter_unit #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_measurement     (s_measurement),
        .s_restart         (s_restart),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_new_estimate    (m_new_estimate),
        .m_new_covariance  (m_new_covariance),
        .m_gain_used       (m_gain_used),
        .m_zero_denominator(m_zero_denominator),
        .m_saturated       (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One filter update: gain, estimate correction and covariance propagation.
    function automatic update_t kalman_update(logic [DW-1:0] z_bits, logic restart);
        update_t res;
        longint  p, d, g, z, est, diff, delta, ne, np, sum;
        res.sat = 1'b0;
        if (restart) begin
            est_q = init_est;
            cov_q = init_cov;
        end
        p   = longint'(cov_q);
        d   = p + longint'(r_noise);
        z   = longint'($signed(z_bits));
        est = longint'(est_q);
        res.zero_den = (d == 0);
        if (d == 0) begin
            g = 0;
        end else begin
            g = (p << FB) / d;
            if (g > GAIN_ONE) g = GAIN_ONE;
        end
        // The correction is floored, so negative differences round away from zero.
        diff  = z - est;
        delta = (diff * g) >>> FB;
        ne    = est + delta;
        if (ne > EST_MAX) begin
            ne      = EST_MAX;
            res.sat = 1'b1;
        end
        if (ne < EST_MIN) begin
            ne      = EST_MIN;
            res.sat = 1'b1;
        end
        np  = (p * (GAIN_ONE - g)) >> FB;
        sum = np + longint'(q_noise);
        if (sum > COV_MAX) begin
            sum     = COV_MAX;
            res.sat = 1'b1;
        end
        est_q          = ne[DW-1:0];
        cov_q          = sum[DW-1:0];
        res.estimate   = est_q;
        res.covariance = cov_q;
        res.gain       = g[FB:0];
        return res;
    endfunction

    // Sample source: a new sample goes out once the previous transfer has happened.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_updates.push_back(kalman_update(s_measurement, s_restart));
                items_accepted++;
                if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
                    src_gap = $urandom_range(1, 13);
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s_measurement <= pending_samples[0].z;
                    s_restart     <= pending_samples[0].restart;
                    s_valid       <= 1'b1;
                    void'(pending_samples.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: checks each transfer against the oldest predicted update.
    always @(posedge aclk) begin
        update_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_updates.size() == 0) begin
                    $error("result transfer with no update expected");
                    error_count++;
                end else begin
                    want = expected_updates.pop_front();
                    if (m_new_estimate !== want.estimate) begin
                        $error("new_estimate: expected %0d, got %0d",
                               want.estimate, m_new_estimate);
                        error_count++;
                    end
                    if (m_new_covariance !== want.covariance) begin
                        $error("new_covariance: expected %0d, got %0d",
                               want.covariance, m_new_covariance);
                        error_count++;
                    end
                    if (m_gain_used !== want.gain) begin
                        $error("gain_used: expected %0d, got %0d", want.gain, m_gain_used);
                        error_count++;
                    end
                    if (m_zero_denominator !== want.zero_den) begin
                        $error("zero_denominator: expected %0d, got %0d",
                               want.zero_den, m_zero_denominator);
                        error_count++;
                    end
                    if (m_saturated !== want.sat) begin
                        $error("saturated: expected %0d, got %0d", want.sat, m_saturated);
                        error_count++;
                    end
                end
                results_checked++;
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct)
                    snk_gap = $urandom_range(1, 13);
            end
        end
    end

    task automatic write_reg(logic [skf_pkg::CFG_INDEX_W-1:0] idx,
                             logic [skf_pkg::CFG_WIDTH-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            skf_pkg::REG_PROCESS_NOISE:      q_noise  = val;
            skf_pkg::REG_MEASUREMENT_NOISE:  r_noise  = val;
            skf_pkg::REG_INITIAL_ESTIMATE:   init_est = val;
            skf_pkg::REG_INITIAL_COVARIANCE: init_cov = val;
            default: ;
        endcase
    endtask

    task automatic push_sample(logic [DW-1:0] z, logic restart);
        sample_t smp;
        smp.z       = z;
        smp.restart = restart;
        pending_samples.push_back(smp);
        items_queued++;
    endtask

    // Waits until every queued sample has been taken and its result checked.
    task automatic wait_drained();
        while (items_accepted != items_queued || results_checked != items_accepted)
            @(posedge aclk);
    endtask

    function automatic logic [DW-1:0] pick_noise();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return $urandom_range(1, 32'h0010_0000);
            4:       return $urandom_range(32'h0000_8000, 32'h0004_0000);
            5:       return 32'h0001_0000;
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_measurement(logic [DW-1:0] centre);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return centre + DW'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            5, 6:          return $urandom;
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:       return DW'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
        endcase
    endfunction

    // A phase of random samples around a centre that the filter should settle on.
    task automatic run_random_phase(int unsigned n);
        logic [DW-1:0] centre;
        centre = $urandom;
        if ($urandom_range(0, 1))
            centre = {{(DW - 24){centre[23]}}, centre[23:0]};
        if ($urandom_range(0, 9) < 7) write_reg(skf_pkg::REG_PROCESS_NOISE, pick_noise());
        if ($urandom_range(0, 9) < 7) write_reg(skf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
        if ($urandom_range(0, 9) < 7)
            write_reg(skf_pkg::REG_INITIAL_ESTIMATE, $urandom_range(0, 1) ? centre : $urandom);
        if ($urandom_range(0, 9) < 7)
            write_reg(skf_pkg::REG_INITIAL_COVARIANCE, pick_noise());
        if ($urandom_range(0, 4) == 0)
            write_reg(skf_pkg::REG_INITIAL_COVARIANCE + 3'($urandom_range(1, 4)), $urandom);
        for (int i = 0; i < n; i++)
            push_sample(pick_measurement(centre),
                        (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0));
        wait_drained();
    endtask

    initial begin
        int unsigned pct_choice[3];
        pct_choice = '{0, 12, 35};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: extremes of the sample and restarts from the reset state.
        src_idle_pct = 20;
        snk_idle_pct = 20;
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);
        push_sample(32'h0001_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1);
        wait_drained();

        // Both covariance and measurement noise zero: the gain is forced to zero.
        write_reg(skf_pkg::REG_PROCESS_NOISE, '0);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, '0);
        write_reg(skf_pkg::REG_INITIAL_ESTIMATE, 32'h7FFF_FFFF);
        write_reg(skf_pkg::REG_INITIAL_COVARIANCE, '0);
        push_sample(32'h8000_0000, 1'b1);
        push_sample(32'h0000_0005, 1'b0);
        wait_drained();

        // Maximum noise everywhere: the covariance sum clips at the top.
        write_reg(skf_pkg::REG_PROCESS_NOISE, '1);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, '1);
        write_reg(skf_pkg::REG_INITIAL_ESTIMATE, 32'h8000_0000);
        write_reg(skf_pkg::REG_INITIAL_COVARIANCE, '1);
        push_sample(32'h7FFF_FFFF, 1'b1);
        push_sample(32'h7FFF_FFFF, 1'b0);
        wait_drained();

        // No measurement noise with nonzero covariance gives a gain of exactly one;
        // writes to indexes past the last register must change nothing.
        write_reg(skf_pkg::REG_PROCESS_NOISE, 32'h0000_0001);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, '0);
        write_reg(skf_pkg::REG_INITIAL_ESTIMATE, '0);
        write_reg(skf_pkg::REG_INITIAL_COVARIANCE, 32'h0001_0000);
        for (int k = 1; k <= 4; k++)
            write_reg(skf_pkg::REG_INITIAL_COVARIANCE + 3'(k), $urandom);
        push_sample(32'h1234_5678, 1'b1);
        push_sample(32'hFFFF_FFFF, 1'b0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = pct_choice[$urandom_range(0, 2)];
                snk_idle_pct = pct_choice[$urandom_range(0, 2)];
            end
            run_random_phase(PHASE_ITEMS);
        end

        repeat (2 * ITEM_CYCLES) @(posedge aclk);
        if (expected_updates.size() != 0) begin
            $error("%0d expected updates never arrived", expected_updates.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/skf_pkg.sv
sv/skf_ctrl.sv
sv/skf_datapath.sv
sv/scalar_kalman_filter_unit.sv
tb/sv/tb_top.sv
